/* rtl/core/ddq_pkg.sv */
// Shared types and codes for the delayed dispatch queue.
package ddq_pkg;

   // Default queue depth handed to the top level.
   localparam int QUEUE_DEPTH_DEF = 8;

   // Request kinds carried on req_tuser.
   localparam logic ACT_ADD     = 1'b0;
   localparam logic ACT_PROCESS = 1'b1;

   // Result kinds carried on rsp_tuser.
   localparam logic [1:0] KIND_ADD_OK  = 2'd0;
   localparam logic [1:0] KIND_DROPPED = 2'd1;
   localparam logic [1:0] KIND_FIRED   = 2'd2;
   localparam logic [1:0] KIND_NONE    = 2'd3;

   // One stored queue entry.
   typedef struct packed {
      logic [7:0]  handler;
      logic [31:0] deadline;
   } entry_type;

   // One result transfer.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] handler;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

/* rtl/core/ddq_store.sv */
// Entry memory: one write port and one read port with registered read data.
module ddq_store #(
   parameter int QUEUE_DEPTH = ddq_pkg::QUEUE_DEPTH_DEF,
   parameter int AW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  ddq_pkg::entry_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output ddq_pkg::entry_type rd_data
);
   import ddq_pkg::*;

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds while no read is issued, so a stalled walk keeps its entry.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ddq_ctrl.sv */
// Queue sequencer: appends entries, walks and compacts the queue, forms results.
module ddq_ctrl #(
   parameter int QUEUE_DEPTH = ddq_pkg::QUEUE_DEPTH_DEF,
   parameter int AW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic [7:0]         req_handler,
   input  logic [31:0]        req_delay,
   input  logic [31:0]        req_now,
   input  logic               out_free,
   output logic               push,
   output ddq_pkg::rsp_type   push_rsp,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output ddq_pkg::entry_type wr_data,
   output logic               rd_en,
   output logic [AW-1:0]      rd_addr,
   input  ddq_pkg::entry_type rd_data
);
   import ddq_pkg::*;

   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] keep_ff, keep_in;
   logic          ev_vld_ff, ev_vld_in;
   logic [31:0]   now_ff, now_in;
   logic          hold_vld_ff, hold_vld_in;
   logic [1:0]    hold_kind_ff, hold_kind_in;
   logic [7:0]    hold_hid_ff, hold_hid_in;

   logic accept;
   logic due;
   logic stall;
   logic issue;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign due       = ev_vld_ff && (rd_data.deadline < now_ff);
   // A second due entry needs the output register to take the one held back.
   assign stall     = due && hold_vld_ff && !out_free;
   assign issue     = (state_ff == ST_WALK) && !stall && (rd_idx_ff < count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      keep_in      = keep_ff;
      ev_vld_in    = ev_vld_ff;
      now_in       = now_ff;
      hold_vld_in  = hold_vld_ff;
      hold_kind_in = hold_kind_ff;
      hold_hid_in  = hold_hid_ff;
      push         = 1'b0;
      push_rsp     = '{kind: KIND_NONE, handler: 8'd0, last: 1'b0};
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = '{handler: req_handler, deadline: req_now + req_delay};
      rd_en        = issue;
      rd_addr      = rd_idx_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_ADD) begin
                  hold_vld_in = 1'b1;
                  hold_hid_in = 8'd0;
                  if (count_ff < DEPTH_C) begin
                     wr_en        = 1'b1;
                     count_in     = count_ff + ONE_C;
                     hold_kind_in = KIND_ADD_OK;
                  end else begin
                     hold_kind_in = KIND_DROPPED;
                  end
               end else begin
                  now_in      = req_now;
                  rd_idx_in   = '0;
                  keep_in     = '0;
                  ev_vld_in   = 1'b0;
                  hold_vld_in = 1'b0;
               end
               state_in = (req_action == ACT_ADD) ? ST_FINISH : ST_WALK;
            end
         end

         ST_WALK: begin
            if (ev_vld_ff && !stall) begin
               if (due) begin
                  // Each fired entry is held until the next one shows it was not the last.
                  if (hold_vld_ff) begin
                     push     = 1'b1;
                     push_rsp = '{kind: KIND_FIRED, handler: hold_hid_ff, last: 1'b0};
                  end
                  hold_vld_in  = 1'b1;
                  hold_kind_in = KIND_FIRED;
                  hold_hid_in  = rd_data.handler;
               end else begin
                  // Survivors move down; the slot written is never the one being read.
                  wr_en   = 1'b1;
                  wr_addr = keep_ff[AW-1:0];
                  wr_data = rd_data;
                  keep_in = keep_ff + ONE_C;
               end
            end
            if (issue) begin
               rd_idx_in = rd_idx_ff + ONE_C;
            end
            if (!stall) begin
               ev_vld_in = issue;
            end
            if (!ev_vld_ff && (rd_idx_ff == count_ff)) begin
               count_in = keep_ff;
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               push = 1'b1;
               if (hold_vld_ff) begin
                  push_rsp = '{kind: hold_kind_ff, handler: hold_hid_ff, last: 1'b1};
               end else begin
                  push_rsp = '{kind: KIND_NONE, handler: 8'd0, last: 1'b1};
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         ev_vld_ff   <= 1'b0;
         hold_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         ev_vld_ff   <= ev_vld_in;
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      keep_ff      <= keep_in;
      now_ff       <= now_in;
      hold_kind_ff <= hold_kind_in;
      hold_hid_ff  <= hold_hid_in;
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count exceeds queue depth");

   a_keep_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (keep_ff <= rd_idx_ff))
      else $error("compaction pointer ran ahead of read pointer");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("write and read hit the same entry in one cycle");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result pushed into a full output register");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && out_free) |=> (state_ff == ST_IDLE))
      else $error("final result did not return the sequencer to idle");
`endif

endmodule

/* rtl/core/delayed_dispatch_queue.sv */
// Top level of the delayed dispatch queue with its result output register.
//
//   Channel   Direction  tdata (low bit up)                            tuser   tlast
//   req_      in         handler_id[7:0] delay_us[39:8] now_us[71:40]  action  -
//   rsp_      out        fired_handler[7:0]                            kind    last
//
// An add writes the entry at the accepting edge, or drops it when the queue is full, and
// the result follows. A process starts at the accepting cycle, makes one read per entry
// through the single read port, drains the read pipeline and sends the final result, with
// survivors written back in order to the front of the queue during the walk.
// Reset empties the queue by clearing the entry count; the memory itself is not cleared.
// A stalled result channel holds the walk when a second due entry needs to go out, and
// the final result waits until the output register is free.
module delayed_dispatch_queue #(
   parameter int QUEUE_DEPTH = ddq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // handler_id, delay_us, now_us
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // fired_handler
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast
);
   import ddq_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic      out_vld_ff, out_vld_in;
   rsp_type   out_ff, out_in;
   logic      out_free;
   logic      push;
   rsp_type   push_rsp;
   logic      wr_en;
   logic [AW-1:0] wr_addr;
   entry_type wr_data;
   logic      rd_en;
   logic [AW-1:0] rd_addr;
   entry_type rd_data;

   assign out_free = !out_vld_ff || rsp_tready;

   ddq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .AW          (AW),
      .CW          (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_action  (req_tuser),
      .req_handler (req_tdata[7:0]),
      .req_delay   (req_tdata[39:8]),
      .req_now     (req_tdata[71:40]),
      .out_free    (out_free),
      .push        (push),
      .push_rsp    (push_rsp),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   ddq_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      if (push) begin
         out_vld_in = 1'b1;
         out_in     = push_rsp;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff.handler;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;

endmodule
